// ----- rtl/trfe_pkg.sv -----
// Shared types and constants for the escaped transmit-request framer.
// No dependencies; imported by every module of the block.
package trfe_pkg;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [7:0]  payload_length;
		logic [15:0] dest_address;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_end;
	} tx_t;

	// One classified request, with all frame fields already worked out.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [7:0]  len_low;
		logic [7:0]  frame_id;
		logic [15:0] dest_address;
		logic [7:0]  checksum;
		logic        first_byte;
		logic        last_byte;
	} cmd_t;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] XON_BYTE   = 8'h11;
	localparam logic [7:0] XOFF_BYTE  = 8'h13;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] TX16_TYPE  = 8'h01;
	localparam logic [7:0] ID_LIMIT   = 8'hFF;
	localparam logic [7:0] ID_FIRST   = 8'h01;
	localparam logic [7:0] LEN_EXTRA  = 8'h05;

	// Byte positions within a frame.
	localparam logic [3:0] POS_START  = 4'd0;
	localparam logic [3:0] POS_LEN_HI = 4'd1;
	localparam logic [3:0] POS_LEN_LO = 4'd2;
	localparam logic [3:0] POS_TYPE   = 4'd3;
	localparam logic [3:0] POS_ID     = 4'd4;
	localparam logic [3:0] POS_ADDR_H = 4'd5;
	localparam logic [3:0] POS_ADDR_L = 4'd6;
	localparam logic [3:0] POS_OPTION = 4'd7;
	localparam logic [3:0] POS_DATA   = 4'd8;
	localparam logic [3:0] POS_CKSUM  = 4'd9;

endpackage

// ----- rtl/trfe_front.sv -----
// Front end: accepts requests, tracks frame id, running sum and frame state,
// and turns each request that opens or continues a frame into a command. Depends on trfe_pkg.
module trfe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  trfe_pkg::req_t req,
	output logic          push,
	output trfe_pkg::cmd_t cmd,
	input  logic          queue_full
);
	import trfe_pkg::*;

	logic [7:0] frame_id_q;
	logic [7:0] sum_acc_q;
	logic       in_frame_q;
	logic       accept;
	logic [7:0] id_next;
	logic [7:0] hdr_sum;
	logic [7:0] sum_next;

	assign req_ready = !queue_full;
	assign accept    = req_valid && req_ready;
	// Bytes outside a frame are dropped without a command.
	assign push      = accept && (req.first_byte || in_frame_q);

	assign id_next = (frame_id_q + 8'd1 == ID_LIMIT) ? ID_FIRST : frame_id_q + 8'd1;
	assign hdr_sum = TX16_TYPE + frame_id_q + req.dest_address[15:8]
		+ req.dest_address[7:0];
	assign sum_next = (req.first_byte ? hdr_sum : sum_acc_q) + req.data_byte;

	always_comb begin
		cmd.data_byte    = req.data_byte;
		cmd.len_low      = req.payload_length + LEN_EXTRA;
		cmd.frame_id     = frame_id_q;
		cmd.dest_address = req.dest_address;
		cmd.checksum     = ~sum_next;
		cmd.first_byte   = req.first_byte;
		cmd.last_byte    = req.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q <= ID_FIRST;
			sum_acc_q  <= 8'd0;
			in_frame_q <= 1'b0;
		end else if (push) begin
			if (req.first_byte) begin
				frame_id_q <= id_next;
			end
			if (req.last_byte) begin
				sum_acc_q  <= 8'd0;
				in_frame_q <= 1'b0;
			end else begin
				sum_acc_q  <= sum_next;
				in_frame_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/trfe_queue.sv -----
// Short command queue between the front and back ends.
// Depends on trfe_pkg for the command type.
module trfe_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  trfe_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output trfe_pkg::cmd_t head_cmd
);
	import trfe_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t            entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/trfe_back.sv -----
// Back end: walks the frame bytes of the head command, escapes them and
// drives the registered output byte stream. Depends on trfe_pkg.
module trfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  trfe_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           tx_valid,
	input  logic           tx_ready,
	output trfe_pkg::tx_t  tx
);
	import trfe_pkg::*;

	logic [3:0] pos_q;
	logic       busy_q;
	logic       esc_q;
	logic       tx_valid_q;
	tx_t        tx_q;

	logic [3:0] pos;
	logic [3:0] end_pos;
	logic [7:0] raw;
	logic       needs_esc;
	logic       byte_done;
	logic       fire;
	logic       cmd_done;
	tx_t        tx_next;

	// A new command starts at the header or, mid-frame, at its data byte.
	assign pos     = busy_q ? pos_q : (head_cmd.first_byte ? POS_START : POS_DATA);
	assign end_pos = head_cmd.last_byte ? POS_CKSUM : POS_DATA;

	always_comb begin
		case (pos)
			POS_START:  raw = START_BYTE;
			POS_LEN_HI: raw = 8'h00;
			POS_LEN_LO: raw = head_cmd.len_low;
			POS_TYPE:   raw = TX16_TYPE;
			POS_ID:     raw = head_cmd.frame_id;
			POS_ADDR_H: raw = head_cmd.dest_address[15:8];
			POS_ADDR_L: raw = head_cmd.dest_address[7:0];
			POS_OPTION: raw = 8'h00;
			POS_DATA:   raw = head_cmd.data_byte;
			POS_CKSUM:  raw = head_cmd.checksum;
			default:    raw = head_cmd.data_byte;
		endcase
	end

	// The start byte itself is never escaped.
	assign needs_esc = (pos != POS_START) && (raw == START_BYTE || raw == ESC_BYTE
		|| raw == XON_BYTE || raw == XOFF_BYTE);
	assign byte_done = !needs_esc || esc_q;
	assign fire      = head_valid && (!tx_valid_q || tx_ready);
	assign cmd_done  = byte_done && (pos == end_pos);
	assign pop       = fire && cmd_done;

	always_comb begin
		tx_next.out_byte  = esc_q ? (raw ^ ESC_XOR) : (needs_esc ? ESC_BYTE : raw);
		tx_next.frame_end = cmd_done && head_cmd.last_byte;
		tx_next.run_end   = cmd_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_START;
			busy_q     <= 1'b0;
			esc_q      <= 1'b0;
			tx_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				tx_valid_q <= 1'b1;
				if (cmd_done) begin
					busy_q <= 1'b0;
					esc_q  <= 1'b0;
				end else if (byte_done) begin
					pos_q  <= pos + 4'd1;
					busy_q <= 1'b1;
					esc_q  <= 1'b0;
				end else begin
					pos_q  <= pos;
					busy_q <= 1'b1;
					esc_q  <= 1'b1;
				end
			end else if (tx_ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			tx_q <= tx_next;
		end
	end

	assign tx_valid = tx_valid_q;
	assign tx       = tx_q;

endmodule

// ----- rtl/tx_request_framer_escaped_unit.sv -----
// Escaped transmit-request framer, top level.
// Depends on trfe_pkg, trfe_front, trfe_queue and trfe_back.
//
// The req channel takes payload bytes; the request that carries first_byte
// also carries payload_length and dest_address and opens a new frame. The
// tx channel delivers the escaped frame one byte a cycle while a command
// waits and tx_ready allows, with frame_end on the last checksum byte and
// run_end on the last byte caused by a request. Requests outside an open
// frame are accepted and dropped. The first byte of a request reaches tx
// through the command queue and the output register. The byte sequencer
// sends one byte per cycle while tx_ready allows, so a payload request
// gives one byte, or two when its byte is escaped; a first request adds
// eight to twelve header bytes and a last request one or two checksum
// bytes. The queue of QUEUE_DEPTH commands absorbs those bursts.
// Reset clears the queue, the frame state and tx_valid; the frame id
// restarts at 1. When tx_ready is low the output byte holds, the sequencer
// waits, and req_ready drops once the queue is full.
module tx_request_framer_escaped_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  trfe_pkg::req_t req,
	output logic           tx_valid,
	input  logic           tx_ready,
	output trfe_pkg::tx_t  tx
);
	import trfe_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic full;
	logic pop;
	logic head_valid;

	trfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push       (push),
		.cmd        (push_cmd),
		.queue_full (full)
	);

	trfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	trfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.tx_valid   (tx_valid),
		.tx_ready   (tx_ready),
		.tx         (tx)
	);

endmodule

// ----- tb/tx_request_framer_escaped_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for tx_request_framer_escaped_unit: a directed table, then random frames.
// Every escaped tx byte is checked against literal table bytes or a predictor kept in this file.
// Depends on trfe_pkg and the block's RTL.
module tx_request_framer_escaped_unit_tb;
	import trfe_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_REQS = 400;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_MOSTLY} rx_mode_e;

	// A directed row; lit_n < 0 means the predictor supplies the expected bytes.
	typedef struct {
		req_t        rq;
		int          lit_n;
		logic [79:0] lit;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic tx_valid;
	logic tx_ready = 1'b0;
	tx_t  tx;

	// Predictor state.
	logic [7:0] nxt_id = ID_FIRST;
	logic [7:0] run_sum = 8'h00;
	logic       frame_open = 1'b0;
	bit         id_wrapped = 1'b0;
	int         frames_opened = 0;

	tx_t      step_bytes[$];
	tx_t      tx_expect_q[$];
	dir_row_t dir_rows[$];

	int err_cnt = 0;
	int busy_reqs = 0;
	int bytes_checked = 0;
	int burst_left = 0;
	bit want_hold = 1'b0;

	tx_request_framer_escaped_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.tx_valid  (tx_valid),
		.tx_ready  (tx_ready),
		.tx        (tx)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("timeout at %0t with %0d tx bytes still expected", $time, tx_expect_q.size());
		$display("tx_request_framer_escaped_unit: mismatch");
		$finish;
	end

	function automatic req_t mk_req(input logic [7:0] d, input logic f, input logic l,
			input logic [7:0] p, input logic [15:0] a);
		req_t r;
		r.data_byte      = d;
		r.first_byte     = f;
		r.last_byte      = l;
		r.payload_length = p;
		r.dest_address   = a;
		return r;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		tx_t t;
		t.out_byte  = b;
		t.frame_end = 1'b0;
		t.run_end   = 1'b0;
		step_bytes.insert(step_bytes.size(), t);
	endfunction

	function automatic void put_escaped(input logic [7:0] b);
		if (b == START_BYTE || b == ESC_BYTE || b == XON_BYTE || b == XOFF_BYTE) begin
			put_byte(ESC_BYTE);
			put_byte(b ^ ESC_XOR);
		end else begin
			put_byte(b);
		end
	endfunction

	function automatic void put_summed(input logic [7:0] b);
		run_sum = run_sum + b;
		put_escaped(b);
	endfunction

	// Fills step_bytes with the escaped bytes that one request should produce.
	function automatic void frame_predict(input req_t r);
		logic [7:0] id;
		step_bytes.delete();
		if (r.first_byte) begin
			id = nxt_id;
			nxt_id = nxt_id + 8'd1;
			if (nxt_id == ID_LIMIT) begin
				nxt_id = ID_FIRST;
				id_wrapped = 1'b1;
			end
			run_sum = 8'h00;
			frame_open = 1'b1;
			frames_opened++;
			put_byte(START_BYTE);
			put_escaped(8'h00);
			put_escaped(r.payload_length + LEN_EXTRA);
			put_summed(TX16_TYPE);
			put_summed(id);
			put_summed(r.dest_address[15:8]);
			put_summed(r.dest_address[7:0]);
			put_summed(8'h00);
		end
		if (frame_open) begin
			put_summed(r.data_byte);
			if (r.last_byte) begin
				put_escaped(8'hFF - run_sum);
				step_bytes[step_bytes.size() - 1].frame_end = 1'b1;
				frame_open = 1'b0;
				run_sum = 8'h00;
			end
			step_bytes[step_bytes.size() - 1].run_end = 1'b1;
		end
	endfunction

	function automatic void add_row(input req_t r, input int n, input logic [79:0] b);
		dir_rows.insert(dir_rows.size(), '{r, n, b});
	endfunction

	// Escape codes show up far more often than a flat draw would give them.
	function automatic logic [7:0] rand_data();
		case ($urandom_range(7))
			0: return START_BYTE;
			1: return ESC_BYTE;
			2: return XON_BYTE;
			3: return XOFF_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Presents one request, waits for it to be taken, queues its expected bytes,
	// then idles the request channel when the current burst runs out.
	task automatic offer(input req_t r, input int lit_n, input logic [79:0] lit);
		tx_t t;
		int k, gap;
		@(negedge clk);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		frame_predict(r);
		if (step_bytes.size() != 0)
			busy_reqs++;
		if (lit_n >= 0) begin
			for (k = 0; k < lit_n; k++) begin
				t.out_byte  = lit[79 - 8 * k -: 8];
				t.run_end   = (k == lit_n - 1);
				t.frame_end = (k == lit_n - 1) && r.last_byte;
				tx_expect_q.insert(tx_expect_q.size(), t);
			end
		end else begin
			foreach (step_bytes[k])
				tx_expect_q.insert(tx_expect_q.size(), step_bytes[k]);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			@(negedge clk) req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
		end
	endtask

	// Sends a frame of len payload bytes; without close it is left open for the
	// next first request to abandon.
	task automatic random_frame(input int len, input bit close);
		logic [7:0] plen;
		int i;
		plen = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'(len);
		for (i = 0; i < len; i++) begin
			offer(mk_req(rand_data(), i == 0, close && (i == len - 1),
				(i == 0) ? plen : 8'($urandom_range(255)), 16'($urandom_range(65535))), -1, '0);
		end
	endtask

	// Short frames dominate so that the frame id wraps within the run.
	function automatic int rand_len();
		int p;
		p = $urandom_range(99);
		if (p < 90)
			return 1;
		else if (p < 97)
			return $urandom_range(2, 4);
		return $urandom_range(5, 20);
	endfunction

	always @(posedge clk) begin
		tx_t want;
		if (arst_n && tx_valid && tx_ready) begin
			if (tx_expect_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected tx byte %h frame_end %b run_end %b", $time,
					tx.out_byte, tx.frame_end, tx.run_end);
			end else begin
				want = tx_expect_q.pop_front();
				bytes_checked++;
				if (tx !== want) begin
					err_cnt++;
					$display("%0t: expected byte %h frame_end %b run_end %b, got byte %h frame_end %b run_end %b",
						$time, want.out_byte, want.frame_end, want.run_end,
						tx.out_byte, tx.frame_end, tx.run_end);
				end
			end
		end
	end

	// Receiver: changes its stall pattern now and then, and once holds off for
	// a long stretch so the block backs up into the request channel.
	initial begin
		rx_mode_e mode;
		int left, k, hold_left;
		mode = RX_OPEN;
		left = 0;
		k = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (want_hold) begin
				want_hold = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				tx_ready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = rx_mode_e'($urandom_range(3));
					left = $urandom_range(10, 80);
				end
				left--;
				k++;
				case (mode)
					RX_OPEN:   tx_ready <= 1'b1;
					RX_RANDOM: tx_ready <= 1'($urandom_range(1));
					RX_SPARSE: tx_ready <= (k % 4 == 0);
					default:   tx_ready <= (k % 7 != 0);
				endcase
			end
		end
	end

	initial begin
		int p, start_reqs;
		add_row(mk_req(8'h55, 1'b0, 1'b0, 8'd1, 16'h1234), 0, '0);
		add_row(mk_req(8'h00, 1'b1, 1'b1, 8'd1, 16'h0000), 10, 80'h7E_00_06_01_01_00_00_00_00_FD);
		add_row(mk_req(8'hFF, 1'b1, 1'b0, 8'd250, 16'hFFFF), 9, 80'h7E_00_FF_01_02_FF_FF_00_FF_00);
		add_row(mk_req(START_BYTE, 1'b0, 1'b0, 8'h00, 16'h0000), -1, '0);
		add_row(mk_req(ESC_BYTE, 1'b0, 1'b0, 8'hFF, 16'hFFFF), -1, '0);
		add_row(mk_req(XON_BYTE, 1'b0, 1'b0, 8'h00, 16'h0000), -1, '0);
		add_row(mk_req(XOFF_BYTE, 1'b0, 1'b0, 8'h00, 16'h0000), -1, '0);
		add_row(mk_req(8'hFF, 1'b0, 1'b0, 8'h00, 16'h0000), -1, '0);
		add_row(mk_req(8'h00, 1'b0, 1'b0, 8'h00, 16'h0000), -1, '0);
		add_row(mk_req(ESC_XOR, 1'b0, 1'b0, 8'h00, 16'h0000), -1, '0);
		add_row(mk_req(8'h5E, 1'b0, 1'b0, 8'h00, 16'h0000), -1, '0);
		add_row(mk_req(8'hA5, 1'b0, 1'b1, 8'h00, 16'h0000), -1, '0);
		// Nothing is open now, so these are dropped.
		add_row(mk_req(8'h3C, 1'b0, 1'b1, 8'h42, 16'h4242), 0, '0);
		add_row(mk_req(8'hC3, 1'b0, 1'b0, 8'hAB, 16'hBEEF), 0, '0);
		// Length low byte and address bytes that need escaping.
		add_row(mk_req(XOFF_BYTE, 1'b1, 1'b0, 8'h79, 16'h7D11), -1, '0);
		// A new first request abandons the open frame.
		add_row(mk_req(ESC_BYTE, 1'b1, 1'b1, 8'h0C, 16'h137E), -1, '0);
		add_row(mk_req(8'hAA, 1'b1, 1'b1, 8'h0E, 16'h5A5A), -1, '0);
		// A length past the legal range wraps in the length byte.
		add_row(mk_req(8'h01, 1'b1, 1'b1, 8'hFF, 16'h00FF), -1, '0);
		add_row(mk_req(8'h80, 1'b1, 1'b0, 8'h00, 16'h8000), -1, '0);
		add_row(mk_req(START_BYTE, 1'b0, 1'b1, 8'h00, 16'h0000), -1, '0);

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (dir_rows[i])
			offer(dir_rows[i].rq, dir_rows[i].lit_n, dir_rows[i].lit);

		want_hold = 1'b1;
		start_reqs = busy_reqs;
		while (busy_reqs - start_reqs < RANDOM_REQS || !id_wrapped) begin
			p = $urandom_range(99);
			if (p < 6)
				offer(mk_req(rand_data(), 1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)),
					16'($urandom_range(65535))), -1, '0);
			else if (p < 12)
				random_frame(rand_len(), 1'b0);
			else
				random_frame(rand_len(), 1'b1);
		end
		@(negedge clk) req_valid <= 1'b0;

		while (tx_expect_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d requests produced output across %0d frames; frame id wrap reached: %0d",
			busy_reqs, frames_opened, id_wrapped);
		$display("%0d tx bytes compared, including a %0d-cycle receiver hold-off",
			bytes_checked, HOLD_CYCLES);
		if (err_cnt == 0)
			$display("tx_request_framer_escaped_unit: match");
		else
			$display("tx_request_framer_escaped_unit: mismatch");
		$finish;
	end

endmodule
